>>> hw/rtl/pic_pkg.sv
// Shared types and constants of the point-in-capsule classifier.
package pic_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int OPND_W     = 73;
    localparam int MAG_W      = 72;
    localparam int PROD_W     = 145;
    localparam int PMAG_W     = 144;

    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_SIZE_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_SIZE_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_SIZE_Z = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FIBER_COUNT = 3'd6;

    localparam logic OPER_LOAD     = 1'b0;
    localparam logic OPER_CLASSIFY = 1'b1;

    localparam logic [30:0] CELL_SIZE_RESET = 31'd65536;

    typedef logic signed [OPND_W-1:0] opnd_t;
    typedef logic signed [PROD_W-1:0] prod_t;

    typedef enum logic [4:0] {
        OP_L_DD, OP_L_AX, OP_L_AY, OP_L_AZ, OP_L_LL, OP_L_Q,
        OP_P_X, OP_P_Y, OP_P_Z,
        OP_F_DX, OP_F_DY, OP_F_DZ, OP_F_NX, OP_F_NY, OP_F_NZ, OP_F_T, OP_F_DD
    } mop_t;

    typedef struct packed {
        logic               operation;
        logic [30:0]        diameter;
        logic [30:0]        length;
        logic signed [17:0] axis_x;
        logic signed [17:0] axis_y;
        logic signed [17:0] axis_z;
        logic signed [31:0] center_x;
        logic signed [31:0] center_y;
        logic signed [31:0] center_z;
        logic [11:0]        cell_i;
        logic [11:0]        cell_j;
        logic [11:0]        cell_k;
    } item_t;

    typedef struct packed {
        logic [61:0]        d2;
        logic [30:0]        len;
        logic [98:0]        q;
        logic signed [17:0] ax;
        logic signed [17:0] ay;
        logic signed [17:0] az;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [31:0] cz;
    } fib_t;

    typedef struct packed {
        logic capture;
        logic mul_start;
        logic wb;
        mop_t op;
        logic mem_we;
        logic mem_rd;
    } cmd_t;

    typedef struct packed {
        logic mul_done;
        logic cap_hit;
        logic in_range;
        logic cyl_hit;
    } sts_t;

endpackage

>>> hw/rtl/pic_if.sv
// Item and result channel interfaces of the point-in-capsule classifier.
interface pic_item_if;
    logic               valid;
    logic               ready;
    logic               operation;
    logic [30:0]        diameter;
    logic [30:0]        length;
    logic signed [17:0] axis_x;
    logic signed [17:0] axis_y;
    logic signed [17:0] axis_z;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] center_z;
    logic [11:0]        cell_i;
    logic [11:0]        cell_j;
    logic [11:0]        cell_k;

    modport source (
        output valid, operation, diameter, length, axis_x, axis_y, axis_z,
               center_x, center_y, center_z, cell_i, cell_j, cell_k,
        input  ready
    );
    modport sink (
        input  valid, operation, diameter, length, axis_x, axis_y, axis_z,
               center_x, center_y, center_z, cell_i, cell_j, cell_k,
        output ready
    );
endinterface

interface pic_result_if;
    logic valid;
    logic ready;
    logic solid;

    modport source (output valid, solid, input ready);
    modport sink (input valid, solid, output ready);
endinterface

>>> hw/rtl/pic_mul.sv
// Shared signed multiplier, one 4-bit digit of the second operand per cycle.
module pic_mul (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  pic_pkg::opnd_t  a,
    input  pic_pkg::opnd_t  b,
    output logic            done,
    output pic_pkg::prod_t  p
);
    logic [pic_pkg::MAG_W-1:0]  amag;
    logic [pic_pkg::MAG_W-1:0]  bmag;
    logic [pic_pkg::PMAG_W-1:0] a_reg;
    logic [pic_pkg::MAG_W-1:0]  b_reg;
    logic [pic_pkg::PMAG_W-1:0] acc_reg;
    logic [pic_pkg::PMAG_W-1:0] part;
    logic                       neg_reg;
    logic                       run_reg;
    logic                       done_reg;
    logic                       last;

    assign amag = pic_pkg::MAG_W'(a[pic_pkg::OPND_W-1] ? -a : a);
    assign bmag = pic_pkg::MAG_W'(b[pic_pkg::OPND_W-1] ? -b : b);
    assign last = (b_reg[pic_pkg::MAG_W-1:4] == '0);

    always_comb
    begin
        part = '0;
        for (int i = 0; i < 4; i++)
        begin
            if (b_reg[i])
            begin
                part = part + (a_reg << i);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= run_reg && last;
            if (start)
            begin
                run_reg <= 1'b1;
            end
            else if (run_reg && last)
            begin
                run_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= pic_pkg::PMAG_W'(amag);
            b_reg   <= bmag;
            acc_reg <= '0;
            neg_reg <= a[pic_pkg::OPND_W-1] ^ b[pic_pkg::OPND_W-1];
        end
        else if (run_reg)
        begin
            acc_reg <= acc_reg + part;
            a_reg   <= a_reg << 4;
            b_reg   <= b_reg >> 4;
        end
    end

    assign done = done_reg;
    assign p    = neg_reg ? -$signed({1'b0, acc_reg}) : $signed({1'b0, acc_reg});

endmodule

>>> hw/rtl/pic_datapath.sv
// Datapath: configuration, fiber table, operand selection and accumulators.
module pic_datapath #(
    parameter int MAX_FIBERS = 64,
    parameter int INDEX_BITS = 12,
    parameter int PTR_W      = 6,
    parameter int CNT_W      = 7
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [pic_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pic_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  pic_pkg::item_t                   item,
    input  pic_pkg::cmd_t                    cmd,
    input  logic [PTR_W-1:0]                 mem_addr,
    output pic_pkg::sts_t                    sts,
    output logic [CNT_W-1:0]                 active
);
    localparam logic [11:0] IDX_MASK =
        (INDEX_BITS >= 12) ? 12'hFFF : 12'((1 << INDEX_BITS) - 1);

    logic signed [31:0] org_reg [3];
    logic [30:0]        cs_reg [3];
    logic [6:0]         fc_reg;

    pic_pkg::item_t     item_reg;
    pic_pkg::fib_t      mem [MAX_FIBERS];
    pic_pkg::fib_t      fib_reg;

    logic [61:0]        d2_reg;
    logic [35:0]        sa_reg;
    logic [61:0]        l2_reg;
    logic [98:0]        q_reg;
    logic signed [49:0] pc_reg [3];
    logic signed [69:0] dot_reg;
    logic [101:0]       nrm_reg;
    logic [135:0]       cv_reg;
    logic signed [140:0] cy_reg;

    logic signed [50:0] r [3];
    logic signed [31:0] cen [3];
    logic [12:0]        odd [3];
    logic [11:0]        idx [3];
    pic_pkg::opnd_t     opa;
    pic_pkg::opnd_t     opb;
    pic_pkg::prod_t     mp;
    logic               mdone;
    logic [99:0]        tabs;
    logic [69:0]        dabs;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int d = 0; d < 3; d++)
            begin
                org_reg[d] <= '0;
                cs_reg[d]  <= pic_pkg::CELL_SIZE_RESET;
            end
            fc_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                pic_pkg::REG_ORIGIN_X:    org_reg[0] <= $signed(cfg_data);
                pic_pkg::REG_ORIGIN_Y:    org_reg[1] <= $signed(cfg_data);
                pic_pkg::REG_ORIGIN_Z:    org_reg[2] <= $signed(cfg_data);
                pic_pkg::REG_CELL_SIZE_X: cs_reg[0]  <= cfg_data[30:0];
                pic_pkg::REG_CELL_SIZE_Y: cs_reg[1]  <= cfg_data[30:0];
                pic_pkg::REG_CELL_SIZE_Z: cs_reg[2]  <= cfg_data[30:0];
                pic_pkg::REG_FIBER_COUNT: fc_reg     <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        if (32'(fc_reg) > MAX_FIBERS)
        begin
            active = CNT_W'(MAX_FIBERS);
        end
        else
        begin
            active = CNT_W'(fc_reg);
        end
    end

    assign cen[0] = fib_reg.cx;
    assign cen[1] = fib_reg.cy;
    assign cen[2] = fib_reg.cz;
    assign idx[0] = item_reg.cell_i & IDX_MASK;
    assign idx[1] = item_reg.cell_j & IDX_MASK;
    assign idx[2] = item_reg.cell_k & IDX_MASK;

    always_comb
    begin
        for (int d = 0; d < 3; d++)
        begin
            r[d]   = 51'(pc_reg[d]) - 51'($signed({cen[d], 1'b0}));
            odd[d] = {idx[d], 1'b1};
        end
    end

    always_comb
    begin
        opa = '0;
        opb = '0;
        unique case (cmd.op)
            pic_pkg::OP_L_DD:
            begin
                opa = pic_pkg::OPND_W'($signed({1'b0, item_reg.diameter}));
                opb = opa;
            end
            pic_pkg::OP_L_AX:
            begin
                opa = pic_pkg::OPND_W'(item_reg.axis_x);
                opb = opa;
            end
            pic_pkg::OP_L_AY:
            begin
                opa = pic_pkg::OPND_W'(item_reg.axis_y);
                opb = opa;
            end
            pic_pkg::OP_L_AZ:
            begin
                opa = pic_pkg::OPND_W'(item_reg.axis_z);
                opb = opa;
            end
            pic_pkg::OP_L_LL:
            begin
                opa = pic_pkg::OPND_W'($signed({1'b0, item_reg.length}));
                opb = opa;
            end
            pic_pkg::OP_L_Q:
            begin
                opa = pic_pkg::OPND_W'($signed({1'b0, l2_reg}));
                opb = pic_pkg::OPND_W'($signed({1'b0, sa_reg}));
            end
            pic_pkg::OP_P_X:
            begin
                opa = pic_pkg::OPND_W'($signed({1'b0, cs_reg[0]}));
                opb = pic_pkg::OPND_W'($signed({1'b0, odd[0]}));
            end
            pic_pkg::OP_P_Y:
            begin
                opa = pic_pkg::OPND_W'($signed({1'b0, cs_reg[1]}));
                opb = pic_pkg::OPND_W'($signed({1'b0, odd[1]}));
            end
            pic_pkg::OP_P_Z:
            begin
                opa = pic_pkg::OPND_W'($signed({1'b0, cs_reg[2]}));
                opb = pic_pkg::OPND_W'($signed({1'b0, odd[2]}));
            end
            pic_pkg::OP_F_DX:
            begin
                opa = pic_pkg::OPND_W'(r[0]);
                opb = pic_pkg::OPND_W'(fib_reg.ax);
            end
            pic_pkg::OP_F_DY:
            begin
                opa = pic_pkg::OPND_W'(r[1]);
                opb = pic_pkg::OPND_W'(fib_reg.ay);
            end
            pic_pkg::OP_F_DZ:
            begin
                opa = pic_pkg::OPND_W'(r[2]);
                opb = pic_pkg::OPND_W'(fib_reg.az);
            end
            pic_pkg::OP_F_NX:
            begin
                opa = pic_pkg::OPND_W'(r[0]);
                opb = opa;
            end
            pic_pkg::OP_F_NY:
            begin
                opa = pic_pkg::OPND_W'(r[1]);
                opb = opa;
            end
            pic_pkg::OP_F_NZ:
            begin
                opa = pic_pkg::OPND_W'(r[2]);
                opb = opa;
            end
            pic_pkg::OP_F_T:
            begin
                opa = pic_pkg::OPND_W'(dot_reg);
                opb = pic_pkg::OPND_W'($signed({1'b0, fib_reg.len}));
            end
            pic_pkg::OP_F_DD:
            begin
                opa = pic_pkg::OPND_W'(dot_reg);
                opb = opa;
            end
        endcase
    end

    pic_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.mul_start),
        .a     (opa),
        .b     (opb),
        .done  (mdone),
        .p     (mp)
    );

    assign tabs = 100'(mp[pic_pkg::PROD_W-1] ? -mp : mp);
    assign dabs = 70'(dot_reg[69] ? -dot_reg : dot_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= item;
        end
        if (cmd.mem_we)
        begin
            mem[mem_addr] <= '{d2: d2_reg, len: item_reg.length, q: q_reg,
                               ax: item_reg.axis_x, ay: item_reg.axis_y,
                               az: item_reg.axis_z, cx: item_reg.center_x,
                               cy: item_reg.center_y, cz: item_reg.center_z};
        end
        if (cmd.mem_rd)
        begin
            fib_reg <= mem[mem_addr];
        end
        if (cmd.wb)
        begin
            unique case (cmd.op)
                pic_pkg::OP_L_DD: d2_reg <= mp[61:0];
                pic_pkg::OP_L_AX: sa_reg <= mp[35:0];
                pic_pkg::OP_L_AY: sa_reg <= sa_reg + mp[35:0];
                pic_pkg::OP_L_AZ: sa_reg <= sa_reg + mp[35:0];
                pic_pkg::OP_L_LL: l2_reg <= mp[61:0];
                pic_pkg::OP_L_Q:  q_reg  <= mp[98:0];
                pic_pkg::OP_P_X:
                    pc_reg[0] <= 50'($signed({org_reg[0], 1'b0})) + $signed(mp[49:0]);
                pic_pkg::OP_P_Y:
                    pc_reg[1] <= 50'($signed({org_reg[1], 1'b0})) + $signed(mp[49:0]);
                pic_pkg::OP_P_Z:
                    pc_reg[2] <= 50'($signed({org_reg[2], 1'b0})) + $signed(mp[49:0]);
                pic_pkg::OP_F_DX: dot_reg <= $signed(mp[69:0]);
                pic_pkg::OP_F_DY: dot_reg <= dot_reg + $signed(mp[69:0]);
                pic_pkg::OP_F_DZ: dot_reg <= dot_reg + $signed(mp[69:0]);
                pic_pkg::OP_F_NX: nrm_reg <= mp[101:0];
                pic_pkg::OP_F_NY: nrm_reg <= nrm_reg + mp[101:0];
                pic_pkg::OP_F_NZ: nrm_reg <= nrm_reg + mp[101:0];
                pic_pkg::OP_F_T:
                    cv_reg <= 136'({nrm_reg, 32'b0}) + 136'(fib_reg.q)
                              - 136'({tabs, 17'b0});
                pic_pkg::OP_F_DD:
                    cy_reg <= $signed(141'({nrm_reg, 32'b0}) - mp[140:0]);
            endcase
        end
    end

    assign sts.mul_done = mdone;
    assign sts.cap_hit  = (cv_reg <= 136'({fib_reg.d2, 32'b0}));
    assign sts.in_range = (dabs <= 70'({fib_reg.len, 16'b0}));
    assign sts.cyl_hit  = (cy_reg <= $signed(141'({fib_reg.d2, 32'b0})));

endmodule

>>> hw/rtl/pic_ctrl.sv
// Controller: sequences loads, cell classification and the fiber loop.
module pic_ctrl #(
    parameter int MAX_FIBERS = 64,
    parameter int PTR_W      = 6,
    parameter int CNT_W      = 7
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  logic                 item_operation,
    output logic                 res_valid,
    input  logic                 res_ready,
    output logic                 res_solid,
    output pic_pkg::cmd_t        cmd,
    input  pic_pkg::sts_t        sts,
    input  logic [CNT_W-1:0]     active,
    output logic [PTR_W-1:0]     mem_addr
);
    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_MUL   = 9'b000000010,
        S_WAIT  = 9'b000000100,
        S_WRITE = 9'b000001000,
        S_FETCH = 9'b000010000,
        S_CHK1  = 9'b000100000,
        S_CHK2  = 9'b001000000,
        S_NEXT  = 9'b010000000,
        S_EMIT  = 9'b100000000
    } state_t;

    state_t          state_reg, state_next;
    pic_pkg::mop_t   op_reg, op_next;
    logic [PTR_W-1:0] ptr_reg, ptr_next;
    logic [PTR_W-1:0] fidx_reg, fidx_next;
    logic            sol_reg, sol_next;
    logic            rv_reg, rv_next;
    logic            rs_reg, rs_next;
    logic [CNT_W:0]  ptr_inc;
    logic [CNT_W:0]  fidx_inc;

    assign ptr_inc  = (CNT_W + 1)'(ptr_reg) + 1'b1;
    assign fidx_inc = (CNT_W + 1)'(fidx_reg) + 1'b1;
    assign item_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        ptr_next   = ptr_reg;
        fidx_next  = fidx_reg;
        sol_next   = sol_reg;
        rv_next    = rv_reg && !res_ready;
        rs_next    = rs_reg;
        cmd        = '0;
        cmd.op     = op_reg;
        mem_addr   = fidx_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.capture = 1'b1;
                    op_next = (item_operation == pic_pkg::OPER_CLASSIFY) ?
                              pic_pkg::OP_P_X : pic_pkg::OP_L_DD;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul_start = 1'b1;
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (sts.mul_done)
                begin
                    cmd.wb = 1'b1;
                    state_next = S_MUL;
                    unique case (op_reg)
                        pic_pkg::OP_L_DD: op_next = pic_pkg::OP_L_AX;
                        pic_pkg::OP_L_AX: op_next = pic_pkg::OP_L_AY;
                        pic_pkg::OP_L_AY: op_next = pic_pkg::OP_L_AZ;
                        pic_pkg::OP_L_AZ: op_next = pic_pkg::OP_L_LL;
                        pic_pkg::OP_L_LL: op_next = pic_pkg::OP_L_Q;
                        pic_pkg::OP_L_Q:  state_next = S_WRITE;
                        pic_pkg::OP_P_X:  op_next = pic_pkg::OP_P_Y;
                        pic_pkg::OP_P_Y:  op_next = pic_pkg::OP_P_Z;
                        pic_pkg::OP_P_Z:
                        begin
                            fidx_next = '0;
                            if (active == '0)
                            begin
                                sol_next   = 1'b0;
                                state_next = S_EMIT;
                            end
                            else
                            begin
                                state_next = S_FETCH;
                            end
                        end
                        pic_pkg::OP_F_DX: op_next = pic_pkg::OP_F_DY;
                        pic_pkg::OP_F_DY: op_next = pic_pkg::OP_F_DZ;
                        pic_pkg::OP_F_DZ: op_next = pic_pkg::OP_F_NX;
                        pic_pkg::OP_F_NX: op_next = pic_pkg::OP_F_NY;
                        pic_pkg::OP_F_NY: op_next = pic_pkg::OP_F_NZ;
                        pic_pkg::OP_F_NZ: op_next = pic_pkg::OP_F_T;
                        pic_pkg::OP_F_T:  state_next = S_CHK1;
                        pic_pkg::OP_F_DD: state_next = S_CHK2;
                    endcase
                end
            end
            S_WRITE:
            begin
                cmd.mem_we = 1'b1;
                mem_addr   = ptr_reg;
                if (ptr_inc >= (CNT_W + 1)'(active) ||
                    ptr_inc >= (CNT_W + 1)'(MAX_FIBERS))
                begin
                    ptr_next = '0;
                end
                else
                begin
                    ptr_next = PTR_W'(ptr_inc);
                end
                state_next = S_IDLE;
            end
            S_FETCH:
            begin
                cmd.mem_rd = 1'b1;
                op_next    = pic_pkg::OP_F_DX;
                state_next = S_MUL;
            end
            S_CHK1:
            begin
                priority if (sts.cap_hit)
                begin
                    sol_next   = 1'b1;
                    state_next = S_EMIT;
                end
                else if (sts.in_range)
                begin
                    op_next    = pic_pkg::OP_F_DD;
                    state_next = S_MUL;
                end
                else
                begin
                    state_next = S_NEXT;
                end
            end
            S_CHK2:
            begin
                if (sts.cyl_hit)
                begin
                    sol_next   = 1'b1;
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_NEXT;
                end
            end
            S_NEXT:
            begin
                if (fidx_inc >= (CNT_W + 1)'(active))
                begin
                    sol_next   = 1'b0;
                    state_next = S_EMIT;
                end
                else
                begin
                    fidx_next  = PTR_W'(fidx_inc);
                    state_next = S_FETCH;
                end
            end
            S_EMIT:
            begin
                if (!rv_reg || res_ready)
                begin
                    rv_next    = 1'b1;
                    rs_next    = sol_reg;
                    state_next = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= pic_pkg::OP_L_DD;
            ptr_reg   <= '0;
            fidx_reg  <= '0;
            sol_reg   <= 1'b0;
            rv_reg    <= 1'b0;
            rs_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            ptr_reg   <= ptr_next;
            fidx_reg  <= fidx_next;
            sol_reg   <= sol_next;
            rv_reg    <= rv_next;
            rs_reg    <= rs_next;
        end
    end

    assign res_valid = rv_reg;
    assign res_solid = rs_reg;

endmodule

>>> hw/rtl/point_in_capsule_classifier.sv
// Point-in-capsule classifier top level: fiber table and cell classification.
// Load: the item is captured, its products are formed and the table is written; a load gives no result.
// Classify: the cell center is computed, then fibers are tested in turn until one holds it or all are tested;
//   every multiply runs on the one shared digit-serial multiplier,
//   which sets the rate.
// One item at a time; the finished result waits in an output register.
// Reset restores configuration defaults and the load pointer; the table is not cleared.
module point_in_capsule_classifier #(
    parameter int MAX_FIBERS = 64,
    parameter int INDEX_BITS = 12
) (
    input  logic                             clk,
    input  logic                             rst_n,
    pic_item_if.sink                         item,
    pic_result_if.source                     result,
    input  logic                             cfg_we,
    input  logic [pic_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pic_pkg::CFG_DATA_W-1:0]   cfg_data
);
    localparam int PTR_W = (MAX_FIBERS > 1) ? $clog2(MAX_FIBERS) : 1;
    localparam int CNT_W = $clog2(MAX_FIBERS + 1);

    pic_pkg::item_t  item_bus;
    pic_pkg::cmd_t   cmd;
    pic_pkg::sts_t   sts;
    logic [CNT_W-1:0] active;
    logic [PTR_W-1:0] mem_addr;

    assign item_bus = '{operation: item.operation, diameter: item.diameter,
                        length: item.length, axis_x: item.axis_x,
                        axis_y: item.axis_y, axis_z: item.axis_z,
                        center_x: item.center_x, center_y: item.center_y,
                        center_z: item.center_z, cell_i: item.cell_i,
                        cell_j: item.cell_j, cell_k: item.cell_k};

    pic_ctrl #(
        .MAX_FIBERS (MAX_FIBERS),
        .PTR_W      (PTR_W),
        .CNT_W      (CNT_W)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item.valid),
        .item_ready     (item.ready),
        .item_operation (item.operation),
        .res_valid      (result.valid),
        .res_ready      (result.ready),
        .res_solid      (result.solid),
        .cmd            (cmd),
        .sts            (sts),
        .active         (active),
        .mem_addr       (mem_addr)
    );

    pic_datapath #(
        .MAX_FIBERS (MAX_FIBERS),
        .INDEX_BITS (INDEX_BITS),
        .PTR_W      (PTR_W),
        .CNT_W      (CNT_W)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item_bus),
        .cmd       (cmd),
        .mem_addr  (mem_addr),
        .sts       (sts),
        .active    (active)
    );

    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        (item.valid && item.ready) |=> !item.ready)
        else $error("item taken while previous item in work");

    a_mem_port: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.mem_we && cmd.mem_rd))
        else $error("table written and read together");

    a_wb_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wb |-> sts.mul_done)
        else $error("write-back without finished product");

    a_start_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mul_start |=> !sts.mul_done)
        else $error("product reported right after start");

endmodule

>>> tb/tb.sv
// Self-checking testbench of the point-in-capsule classifier: predicted cell solidity vs. DUT.
`timescale 1ns / 1ps

module tb;
    typedef logic signed [191:0] wide_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [pic_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [pic_pkg::CFG_DATA_W-1:0] cfg_data;

    pic_item_if item_ch ();
    pic_result_if res_ch ();

    point_in_capsule_classifier dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_ch),
        .result    (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    pic_pkg::item_t pending_items[$];
    bit    solid_expected[$];

    longint org[3];
    longint csz[3];
    int     fiber_cnt;
    longint fdia[64];
    longint flen[64];
    int     fax[64][3];
    int     fcen[64][3];
    bit     fwritten[64];
    int     load_slot;

    int  idle_pct;
    int  stall_pct;
    longint cyc;
    longint hold_end;
    int  err_cnt;
    int  n_loads;
    int  n_cells;
    int  n_solid;
    int  n_phases;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cyc <= 0;
        else
            cyc <= cyc + 1;
    end

    initial
    begin
        #40000000;
        $display("tb: errors");
        $finish;
    end

    function automatic int active_fibers();
        return (fiber_cnt > 64) ? 64 : fiber_cnt;
    endfunction

    function automatic bit table_ready();
        for (int s = 0; s < active_fibers(); s++)
            if (!fwritten[s])
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic bit inside_capsule(int f, longint p[3]);
        wide_t r, a, rs, ha, e1, e2, dot, nrm, c1, c2, lim, h16;
        dot = 0;
        nrm = 0;
        c1 = 0;
        c2 = 0;
        lim = wide_t'(fdia[f] * fdia[f]) <<< 32;
        for (int d = 0; d < 3; d++)
        begin
            r   = wide_t'(p[d] - 2 * longint'(fcen[f][d]));
            a   = wide_t'(fax[f][d]);
            dot = dot + r * a;
            nrm = nrm + r * r;
            rs  = r * wide_t'(65536);
            ha  = wide_t'(flen[f] * longint'(fax[f][d]));
            e1  = rs + ha;
            e2  = rs - ha;
            c1  = c1 + e1 * e1;
            c2  = c2 + e2 * e2;
        end
        if (c1 <= lim || c2 <= lim)
            return 1'b1;
        h16 = wide_t'(flen[f]) * wide_t'(65536);
        if (dot > h16 || dot < -h16)
            return 1'b0;
        return ((nrm <<< 32) - dot * dot) <= lim;
    endfunction

    function automatic bit cell_is_solid(pic_pkg::item_t it);
        longint p[3];
        p[0] = 2 * org[0] + (2 * longint'(it.cell_i) + 1) * csz[0];
        p[1] = 2 * org[1] + (2 * longint'(it.cell_j) + 1) * csz[1];
        p[2] = 2 * org[2] + (2 * longint'(it.cell_k) + 1) * csz[2];
        for (int f = 0; f < active_fibers(); f++)
            if (inside_capsule(f, p))
                return 1'b1;
        return 1'b0;
    endfunction

    task automatic add_item(pic_pkg::item_t it);
        int s;
        int nx;
        bit sol;
        pending_items.push_back(it);
        if (it.operation == pic_pkg::OPER_LOAD)
        begin
            s = (load_slot >= 64) ? 0 : load_slot;
            fdia[s] = it.diameter;
            flen[s] = it.length;
            fax[s][0] = it.axis_x;
            fax[s][1] = it.axis_y;
            fax[s][2] = it.axis_z;
            fcen[s][0] = it.center_x;
            fcen[s][1] = it.center_y;
            fcen[s][2] = it.center_z;
            fwritten[s] = 1'b1;
            nx = s + 1;
            if (nx >= active_fibers() || nx >= 64)
                nx = 0;
            load_slot = nx;
            n_loads++;
        end
        else
        begin
            sol = cell_is_solid(it);
            solid_expected.push_back(sol);
            n_cells++;
            n_solid += sol;
        end
    endtask

    task automatic wait_idle();
        while (pending_items.size() != 0 || solid_expected.size() != 0)
            @(posedge clk);
        repeat (150) @(posedge clk);
    endtask

    task automatic set_cfg(longint ox, longint oy, longint oz,
                           longint sx, longint sy, longint sz, int n);
        logic [31:0] vals[7];
        vals[0] = ox[31:0];
        vals[1] = oy[31:0];
        vals[2] = oz[31:0];
        vals[3] = {1'b0, sx[30:0]};
        vals[4] = {1'b0, sy[30:0]};
        vals[5] = {1'b0, sz[30:0]};
        vals[6] = {25'd0, n[6:0]};
        for (int r = 0; r < 7; r++)
        begin
            @(posedge clk);
            cfg_we    <= 1'b1;
            cfg_index <= pic_pkg::CFG_IDX_W'(r);
            cfg_data  <= vals[r];
        end
        @(posedge clk);
        cfg_we <= 1'b0;
        org[0] = longint'(signed'(vals[0]));
        org[1] = longint'(signed'(vals[1]));
        org[2] = longint'(signed'(vals[2]));
        csz[0] = vals[3];
        csz[1] = vals[4];
        csz[2] = vals[5];
        fiber_cnt = vals[6];
    endtask

    function automatic pic_pkg::item_t make_load(longint dia, longint len,
                                                 int ax, int ay, int az,
                                                 longint cx, longint cy, longint cz);
        pic_pkg::item_t it;
        it = '0;
        it.operation = pic_pkg::OPER_LOAD;
        it.diameter = dia[30:0];
        it.length = len[30:0];
        it.axis_x = ax[17:0];
        it.axis_y = ay[17:0];
        it.axis_z = az[17:0];
        it.center_x = cx[31:0];
        it.center_y = cy[31:0];
        it.center_z = cz[31:0];
        it.cell_i = 12'($urandom);
        it.cell_j = 12'($urandom);
        it.cell_k = 12'($urandom);
        return it;
    endfunction

    function automatic pic_pkg::item_t make_cell(int i, int j, int k);
        pic_pkg::item_t it;
        it = '0;
        it.operation = pic_pkg::OPER_CLASSIFY;
        it.diameter = 31'($urandom);
        it.length = 31'($urandom);
        it.cell_i = i[11:0];
        it.cell_j = j[11:0];
        it.cell_k = k[11:0];
        return it;
    endfunction

    function automatic pic_pkg::item_t rand_load();
        longint c[3];
        int a[3];
        int sel;
        if ($urandom_range(99) < 15)
            return make_load($urandom, $urandom, $urandom, $urandom, $urandom,
                             $urandom, $urandom, $urandom);
        for (int d = 0; d < 3; d++)
        begin
            c[d] = org[d] + ((2 * longint'($urandom_range(0, 15)) + 1) * csz[d]) / 2
                   + longint'($urandom_range(0, 32767)) - 16384;
            a[d] = 0;
        end
        sel = $urandom_range(0, 2);
        case ($urandom_range(0, 3))
            0, 1: a[sel] = $urandom_range(0, 1) ? 65536 : -65536;
            2:
            begin
                a[sel] = $urandom_range(0, 1) ? 46341 : -46341;
                a[(sel + 1) % 3] = $urandom_range(0, 1) ? 46341 : -46341;
            end
            default:
                for (int d = 0; d < 3; d++)
                    a[d] = int'($urandom_range(0, 75000)) - 37500;
        endcase
        return make_load(longint'($urandom_range(0, 4)) * csz[0] + $urandom_range(0, 65535),
                         longint'($urandom_range(0, 8)) * csz[0] + $urandom_range(0, 65535),
                         a[0], a[1], a[2], c[0], c[1], c[2]);
    endfunction

    function automatic pic_pkg::item_t rand_cell();
        if ($urandom_range(99) < 15)
            return make_cell($urandom_range(0, 4095), $urandom_range(0, 4095),
                             $urandom_range(0, 4095));
        return make_cell($urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 15));
    endfunction

    task automatic random_phase(int n_items, int load_pct);
        for (int k = 0; k < n_items; k++)
        begin
            if ($urandom_range(99) < load_pct || !table_ready())
                add_item(rand_load());
            else
                add_item(rand_cell());
        end
        n_phases++;
    endtask

    function automatic longint pick_origin();
        case ($urandom_range(0, 9))
            0: return -64'sd2147483648;
            1: return 64'sd2147483647;
            2: return longint'(signed'($urandom));
            default: return longint'($urandom_range(0, 1 << 25)) - (1 << 24);
        endcase
    endfunction

    function automatic longint pick_size();
        case ($urandom_range(0, 11))
            0: return 0;
            1: return 2147483647;
            2: return $urandom & 32'h7FFFFFFF;
            default: return $urandom_range(4096, 262144);
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        pic_pkg::item_t nxt;
        if (!rst_n)
            item_ch.valid <= 1'b0;
        else
        begin
            if (item_ch.valid && item_ch.ready)
                nxt = pending_items.pop_front();
            if (item_ch.valid && !item_ch.ready)
                item_ch.valid <= 1'b1;
            else if (pending_items.size() != 0 && $urandom_range(99) >= idle_pct)
            begin
                nxt = pending_items[0];
                item_ch.valid     <= 1'b1;
                item_ch.operation <= nxt.operation;
                item_ch.diameter  <= nxt.diameter;
                item_ch.length    <= nxt.length;
                item_ch.axis_x    <= nxt.axis_x;
                item_ch.axis_y    <= nxt.axis_y;
                item_ch.axis_z    <= nxt.axis_z;
                item_ch.center_x  <= nxt.center_x;
                item_ch.center_y  <= nxt.center_y;
                item_ch.center_z  <= nxt.center_z;
                item_ch.cell_i    <= nxt.cell_i;
                item_ch.cell_j    <= nxt.cell_j;
                item_ch.cell_k    <= nxt.cell_k;
            end
            else
                item_ch.valid <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        bit want;
        if (!rst_n)
            res_ch.ready <= 1'b0;
        else
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                if (solid_expected.size() == 0)
                begin
                    $error("unexpected result transfer: solid=%0b", res_ch.solid);
                    err_cnt++;
                end
                else
                begin
                    want = solid_expected.pop_front();
                    if (res_ch.solid !== want)
                    begin
                        $error("solid mismatch: expected %0b, got %0b", want, res_ch.solid);
                        err_cnt++;
                    end
                end
            end
            res_ch.ready <= (cyc >= hold_end) && ($urandom_range(99) >= stall_pct);
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        item_ch.valid = 1'b0;
        item_ch.operation = pic_pkg::OPER_LOAD;
        item_ch.diameter = '0;
        item_ch.length = '0;
        item_ch.axis_x = '0;
        item_ch.axis_y = '0;
        item_ch.axis_z = '0;
        item_ch.center_x = '0;
        item_ch.center_y = '0;
        item_ch.center_z = '0;
        item_ch.cell_i = '0;
        item_ch.cell_j = '0;
        item_ch.cell_k = '0;
        res_ch.ready = 1'b0;
        idle_pct = 0;
        stall_pct = 0;
        hold_end = 0;
        err_cnt = 0;
        n_loads = 0;
        n_cells = 0;
        n_solid = 0;
        n_phases = 0;
        org = '{0, 0, 0};
        csz = '{65536, 65536, 65536};
        fiber_cnt = 0;
        load_slot = 0;
        for (int s = 0; s < 64; s++)
            fwritten[s] = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (3) @(posedge clk);

        add_item(make_cell(0, 0, 0));
        add_item(make_load(2147483647, 2147483647, -131072, -131072, -131072,
                           -64'sd2147483648, -64'sd2147483648, -64'sd2147483648));
        wait_idle();
        set_cfg(0, 0, 0, 65536, 65536, 65536, 4);
        add_item(make_load(131072, 262144, 65536, 0, 0, 229376, 229376, 229376));
        add_item(make_load(0, 0, 131071, 131071, 131071, 2147483647, 2147483647, 2147483647));
        add_item(make_load(65536, 65536, -131072, 0, 5000, -64'sd2147483648, 0, 2147483647));
        add_item(make_load(65536, 0, 0, 0, 65536, 688128, 688128, 688128));
        add_item(make_cell(3, 3, 3));
        add_item(make_cell(5, 3, 3));
        add_item(make_cell(6, 3, 3));
        add_item(make_cell(7, 3, 3));
        add_item(make_cell(3, 5, 3));
        add_item(make_cell(10, 10, 10));
        add_item(make_cell(10, 10, 11));
        add_item(make_cell(4095, 4095, 4095));
        add_item(make_cell(0, 4095, 0));
        wait_idle();
        set_cfg(0, 0, 0, 65536, 65536, 65536, 6);
        for (int k = 0; k < 5; k++)
            add_item(rand_load());
        wait_idle();
        set_cfg(0, 0, 0, 65536, 65536, 65536, 3);
        add_item(rand_load());
        add_item(rand_load());
        add_item(rand_cell());
        wait_idle();

        for (int ph = 0; ph < 16; ph++)
        begin
            idle_pct  = (ph % 4 == 1 || ph % 4 == 3) ? ((ph % 4 == 1) ? 86 : 36) : 0;
            stall_pct = (ph % 4 == 2) ? 86 : ((ph % 4 == 3) ? 36 : 0);
            if (ph == 4)
                set_cfg(-64'sd2147483648, 2147483647, 0, 0, 2147483647, 65536,
                        $urandom_range(1, 6));
            else
                set_cfg(pick_origin(), pick_origin(), pick_origin(),
                        pick_size(), pick_size(), pick_size(),
                        (ph == 8) ? 0 : $urandom_range(1, 6));
            if (ph == 2)
            begin
                @(negedge clk);
                hold_end = cyc + 3000;
            end
            random_phase(55, 30);
            wait_idle();
        end

        idle_pct = 0;
        stall_pct = 0;
        set_cfg(0, 0, 0, 16384, 16384, 16384, 64);
        random_phase(72, 0);
        wait_idle();
        set_cfg(0, 0, 0, 16384, 16384, 16384, 127);
        for (int k = 0; k < 4; k++)
            add_item(rand_cell());
        wait_idle();

        $display("summary: %0d fiber loads, %0d cells classified (%0d solid), %0d phases",
                 n_loads, n_cells, n_solid, n_phases);
        $display("summary: sender/receiver idling 0/86/36 pct, long receiver hold, full table");
        if (err_cnt == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end
endmodule
